>>> rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants, codes and control types of the sorted list unit.
// ----------------------------------------------------------------------------
package sli_pkg;

  // Storage geometry.
  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Field widths of the stream words.
  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;
  localparam int FUNC_W      = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int POS_CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_FIELDS_W  = DATA_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + COUNT_OUT_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes carried in the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_PLACE,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic walk;
    logic place;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_walk;
    logic need_place;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/sorted_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit
// Ascending list of signed 32-bit values with insert, remove and read.
// ----------------------------------------------------------------------------
// The input channel takes one command word at a time: in_tuser selects the
// operation (insert, remove or read) and in_tdata carries the value and the
// read position. Each command yields exactly one result word on the output
// channel with the read value, the entry count after the operation, an
// applied flag and a flag for an insert refused because the list is full.
// The entries sit in a single-port-write, registered-read memory that is
// walked one entry per cycle. An insert walks down from the top entry,
// moving every larger entry up by one, and stops at the first entry not
// above the value or at the bottom. A remove scans the whole list, closing
// the gap behind the match. A valid read is a single access; refused or
// unknown commands, reads past the count and removes from an empty list
// skip the walk. The next word is accepted in the cycle after the result is
// registered. Reset clears the entry count, so the list starts empty and
// needs no clearing pass. The result word is held in an output register;
// while the receiver stalls, the next command may still be accepted and
// worked on, and it waits at its end until the held word is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // value [31:0], position [37:32], zero padding above
  input  logic [sli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func [1:0]
  input  logic [sli_pkg::FUNC_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_value [31:0], count [38:32], applied [39], full_res [40],
  // zero padding above
  output logic [sli_pkg::OUT_TDATA_W-1:0] out_tdata
);

  sli_pkg::cmd_t  cmd;
  sli_pkg::stat_t st;

  // The sequencer decides which step runs; the datapath owns all storage.
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sli_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer of the sorted list unit: steps one operation through setup,
// memory walk, placement and result hand-off.
// ----------------------------------------------------------------------------
module sli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  sli_pkg::stat_t st,
  output sli_pkg::cmd_t  cmd
);

  sli_pkg::state_t state_r;
  sli_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sli_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sli_pkg::ST_SETUP;
        end
      end
      sli_pkg::ST_SETUP: begin
        if (st.need_walk) begin
          state_nxt = sli_pkg::ST_WALK;
        end else if (st.need_place) begin
          state_nxt = sli_pkg::ST_PLACE;
        end else begin
          state_nxt = sli_pkg::ST_RESULT;
        end
      end
      sli_pkg::ST_WALK: begin
        if (st.walk_done) begin
          state_nxt = st.need_place ? sli_pkg::ST_PLACE : sli_pkg::ST_RESULT;
        end
      end
      sli_pkg::ST_PLACE: begin
        state_nxt = sli_pkg::ST_RESULT;
      end
      sli_pkg::ST_RESULT: begin
        if (st.out_free) begin
          state_nxt = sli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sli_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    case (state_r)
      sli_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      sli_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      sli_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
      end
      sli_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
      end
      sli_pkg::ST_RESULT: begin
        cmd.finish = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/sli_dp.sv
// ----------------------------------------------------------------------------
// sli_dp
// Datapath of the sorted list unit: entry memory, entry count, walk
// counters and the output word register.
// ----------------------------------------------------------------------------
module sli_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sli_pkg::cmd_t                      cmd,
  output sli_pkg::stat_t                     st,
  input  logic [sli_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [sli_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sli_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW = sli_pkg::ADDR_W;
  localparam int CW = sli_pkg::CNT_W;
  localparam int DW = sli_pkg::DATA_W;
  localparam int PAD_W = sli_pkg::OUT_TDATA_W - sli_pkg::OUT_FIELDS_W;

  logic [DW-1:0] mem [sli_pkg::CAPACITY];

  // Operation registers.
  logic [sli_pkg::FUNC_W-1:0] op_r;
  logic signed [DW-1:0]       val_r;
  logic [sli_pkg::POS_W-1:0]  pos_r;
  logic [CW-1:0]              cnt_r;

  // Walk state: read issue side and evaluate side, which follows it in the next cycle.
  logic [AW-1:0] iss_idx_r;
  logic          iss_act_r;
  logic [AW-1:0] eval_idx_r;
  logic          eval_vld_r;
  logic [DW-1:0] rdata_r;
  logic          found_r;
  logic [AW-1:0] slot_r;
  logic [DW-1:0] rd_r;

  // Output word.
  logic                         out_vld_r;
  logic [DW-1:0]                out_rd_r;
  logic [sli_pkg::COUNT_OUT_W-1:0] out_cnt_r;
  logic                         out_app_r;
  logic                         out_full_r;

  logic          is_ins;
  logic          is_rem;
  logic          is_rd;
  logic          full;
  logic          pos_ok;
  logic [CW-1:0] cnt_last;
  logic          gt;
  logic          eq;
  logic          eval_last;
  logic          iss_last;
  logic          eval_step;
  logic          walk_done;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          applied;

  always_comb begin
    is_ins   = (op_r == sli_pkg::FUNC_INSERT);
    is_rem   = (op_r == sli_pkg::FUNC_REMOVE);
    is_rd    = (op_r == sli_pkg::FUNC_READ);
    full     = (cnt_r == CW'(sli_pkg::CAPACITY));
    pos_ok   = (sli_pkg::POS_CMP_W'(pos_r) < sli_pkg::POS_CMP_W'(cnt_r));
    cnt_last = cnt_r - CW'(1);
    gt       = ($signed(rdata_r) > val_r);
    eq       = (rdata_r == val_r);

    // An insert walks down and stops at the first entry not above the value
    // or at the bottom; a remove walks the whole list; a read is one access.
    if (is_ins) begin
      eval_last = gt ? (eval_idx_r == '0) : 1'b1;
      iss_last  = (iss_idx_r == '0);
    end else if (is_rem) begin
      eval_last = (CW'(eval_idx_r) == cnt_last);
      iss_last  = (CW'(iss_idx_r) == cnt_last);
    end else begin
      eval_last = 1'b1;
      iss_last  = 1'b1;
    end

    eval_step = cmd.walk && eval_vld_r;
    walk_done = eval_step && eval_last;

    we    = cmd.place || (eval_step && ((is_ins && gt) || (is_rem && found_r)));
    if (cmd.place) begin
      waddr = slot_r;
      wdata = val_r;
    end else begin
      waddr = is_ins ? (eval_idx_r + AW'(1)) : (eval_idx_r - AW'(1));
      wdata = rdata_r;
    end

    if (is_ins) begin
      applied = !full;
    end else if (is_rem) begin
      applied = found_r;
    end else if (is_rd) begin
      applied = pos_ok;
    end else begin
      applied = 1'b0;
    end

    st.need_walk  = (is_ins && !full && (cnt_r != '0)) ||
                    (is_rem && (cnt_r != '0)) ||
                    (is_rd && pos_ok);
    st.need_place = is_ins && !full;
    st.walk_done  = walk_done;
    st.out_free   = !out_vld_r || out_tready;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[iss_idx_r];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_tuser;
      val_r <= in_tdata[DW-1:0];
      pos_r <= in_tdata[DW +: sli_pkg::POS_W];
    end
    if (cmd.setup) begin
      if (is_ins) begin
        iss_idx_r <= AW'(cnt_last);
      end else if (is_rem) begin
        iss_idx_r <= '0;
      end else begin
        iss_idx_r <= AW'(pos_r);
      end
      slot_r <= '0;
    end else if (cmd.walk && iss_act_r && !iss_last) begin
      iss_idx_r <= is_ins ? (iss_idx_r - AW'(1)) : (iss_idx_r + AW'(1));
    end
    if (cmd.walk && iss_act_r) begin
      eval_idx_r <= iss_idx_r;
    end
    if (eval_step && is_ins && !gt) begin
      slot_r <= eval_idx_r + AW'(1);
    end
    if (eval_step && is_rd) begin
      rd_r <= rdata_r;
    end
    if (cmd.finish) begin
      out_rd_r   <= (is_rd && pos_ok) ? rd_r : '0;
      out_app_r  <= applied;
      out_full_r <= is_ins && full;
      if (is_ins && !full) begin
        out_cnt_r <= sli_pkg::COUNT_OUT_W'(cnt_r + CW'(1));
      end else if (is_rem && found_r) begin
        out_cnt_r <= sli_pkg::COUNT_OUT_W'(cnt_last);
      end else begin
        out_cnt_r <= sli_pkg::COUNT_OUT_W'(cnt_r);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      iss_act_r  <= 1'b0;
      eval_vld_r <= 1'b0;
      found_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.setup) begin
        iss_act_r  <= st.need_walk;
        eval_vld_r <= 1'b0;
        found_r    <= 1'b0;
      end else if (cmd.walk) begin
        if (walk_done) begin
          iss_act_r  <= 1'b0;
          eval_vld_r <= 1'b0;
        end else begin
          iss_act_r  <= iss_act_r && !iss_last;
          eval_vld_r <= iss_act_r;
        end
        if (eval_step && is_rem && eq) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (is_ins && !full) begin
          cnt_r <= cnt_r + CW'(1);
        end else if (is_rem && found_r) begin
          cnt_r <= cnt_last;
        end
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_full_r, out_app_r, out_cnt_r, out_rd_r};

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted list insert/remove unit.
// ----------------------------------------------------------------------------
// A predictor mirrors the list in the bench. It tracks the stored values in
// ascending signed order and the entry count. Every accepted command word
// produces one expected result word in a queue, and every result word that
// the unit hands out is checked against the oldest one.
//
// The stimulus opens with a short directed part. That part covers the
// empty list, the extreme values, duplicates, absent removes, invalid read
// positions and the unused operation code.
//
// A long random part follows. It cycles through three phases:
//   - fill, which pushes the list to full and into refused inserts,
//   - mixed traffic,
//   - drain.
//
// Both channels idle at random. One long window runs with no idling, and the
// sender three times waits for the unit to drain completely.
// ----------------------------------------------------------------------------
module tb;
  import sli_pkg::*;

  // Code 3 is not an operation; the unit must answer it without any change.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1100;
  localparam int PHASE_LEN    = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     applied;
    logic                     full_res;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Predictor and result queue.
  // --------------------------------------------------------------------------
  class sorted_list_scoreboard;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    int                       n_stored;
    list_result_t             expected_q [$];
    int                       failures;

    function new();
      n_stored = 0;
      failures = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic signed [DATA_W-1:0] entry_at(int idx);
      return entries[idx];
    endfunction

    // Applies one accepted command to the mirrored list and queues its result.
    function void note_input(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value,
                             logic [POS_W-1:0] pos);
      list_result_t res;
      int           slot;
      res = '0;
      if (func == FUNC_INSERT) begin
        if (n_stored >= CAPACITY) begin
          res.full_res = 1'b1;
        end else begin
          // New value goes after every entry that is not greater than it.
          slot = n_stored;
          for (int i = 0; i < n_stored; i++) begin
            if (entries[i] > value) begin
              slot = i;
              break;
            end
          end
          for (int i = n_stored; i > slot; i--) entries[i] = entries[i-1];
          entries[slot] = value;
          n_stored++;
          res.applied = 1'b1;
        end
      end else if (func == FUNC_REMOVE) begin
        for (int i = 0; i < n_stored; i++) begin
          if (entries[i] == value) begin
            for (int j = i; j + 1 < n_stored; j++) entries[j] = entries[j+1];
            n_stored--;
            res.applied = 1'b1;
            break;
          end
        end
      end else if (func == FUNC_READ) begin
        if (int'(pos) < n_stored) begin
          res.read_value = entries[pos];
          res.applied    = 1'b1;
        end
      end
      res.count = n_stored[COUNT_OUT_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= 10)
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Checks one result word against the oldest expectation.
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      list_result_t want;
      list_result_t got;
      got.read_value = word[31:0];
      got.count      = word[38:32];
      got.applied    = word[39];
      got.full_res   = word[40];
      if (expected_q.size() == 0) begin
        report("unexpected result word", '0, word);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value)
        report("read_value", want.read_value, got.read_value);
      if (got.count !== want.count) report("count", want.count, got.count);
      if (got.applied !== want.applied) report("applied", want.applied, got.applied);
      if (got.full_res !== want.full_res) report("full_res", want.full_res, got.full_res);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the unit.
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  always #2 clk = ~clk;

  sorted_list_insert_remove_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sorted_list_scoreboard sb = new();

  // While set, neither side inserts idle cycles.
  bit no_idle;
  int cycles = 0;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls in about a quarter of the cycles outside the quiet window.
  always @(negedge clk) begin
    if (rst_n) out_tready = no_idle || ($urandom_range(99) >= 25);
  end

  // Result words are sampled at the rising edge where the handshake completes.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Sender tasks.
  // --------------------------------------------------------------------------
  // Presents one command word, possibly after idle cycles. The word is noted
  // in the predictor at the edge where it is taken. tvalid stays high after
  // the handshake, so a following word can go out back to back.
  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, pos, value};
    do @(posedge clk); while (!in_tready);
    sb.note_input(func, value, pos);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Picks a value: small values give many duplicates, extremes test the signed order.
  function automatic logic [DATA_W-1:0] pick_value(bit prefer_stored);
    int r;
    r = $urandom_range(99);
    if (prefer_stored && sb.n_stored > 0 && r < 70)
      return sb.entry_at($urandom_range(sb.n_stored - 1));
    if (r < 15) return $urandom_range(6) - 3;
    if (r < 25) begin
      case ($urandom_range(4))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_MIN + 1;
        3:       return '1;
        default: return '0;
      endcase
    end
    if (r < 40 && sb.n_stored > 0) return sb.entry_at($urandom_range(sb.n_stored - 1));
    return $urandom();
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  int                phase;
  int                roll;
  int                ins_pct;
  int                rem_pct;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  pos;

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_INSERT;
    no_idle    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Commands against the empty list.
    send_word(FUNC_READ, '0, '0);
    send_word(FUNC_REMOVE, 32'd5, '1);
    send_word(FUNC_UNUSED, '1, '1);
    // Extremes and duplicates. Equal values must land after the ones stored.
    send_word(FUNC_INSERT, '0, '0);
    send_word(FUNC_INSERT, VAL_MIN, '1);
    send_word(FUNC_INSERT, VAL_MAX, 6'd21);
    send_word(FUNC_INSERT, '1, 6'd42);
    send_word(FUNC_INSERT, 32'd1, '0);
    send_word(FUNC_INSERT, 32'd1, '1);
    send_word(FUNC_INSERT, '1, '0);
    send_word(FUNC_INSERT, VAL_MIN + 1, '0);
    // Reads across the list, then at and past the count.
    send_word(FUNC_READ, '1, 6'd0);
    send_word(FUNC_READ, 32'h5555_aaaa, 6'd3);
    send_word(FUNC_READ, '0, 6'd7);
    send_word(FUNC_READ, '0, 6'd8);
    send_word(FUNC_READ, '0, 6'd63);
    // Removing takes the first equal entry; a value that is absent changes nothing.
    send_word(FUNC_REMOVE, 32'd1, '0);
    send_word(FUNC_REMOVE, VAL_MAX, '0);
    send_word(FUNC_REMOVE, 32'd12345, '0);
    send_word(FUNC_REMOVE, VAL_MIN, '1);
    send_word(FUNC_UNUSED, '0, '0);
    send_word(FUNC_READ, '0, 6'd5);

    // Random traffic. The phases cycle through fill, mixed traffic and drain.
    // The fill phase pushes the list to full and then into refused inserts.
    for (int it = 0; it < RANDOM_WORDS; it++) begin
      no_idle = (it >= 450 && it < 650);
      if (it == 300 || it == 900) wait_drained();
      phase = (it / PHASE_LEN) % 3;
      case (phase)
        0:       begin ins_pct = 75; rem_pct = 12; end
        1:       begin ins_pct = 40; rem_pct = 35; end
        default: begin ins_pct = 15; rem_pct = 60; end
      endcase
      roll = $urandom_range(99);
      pos  = $urandom_range(63);
      if (roll < 3) begin
        send_word(FUNC_UNUSED, $urandom(), pos);
      end else if (roll < ins_pct) begin
        send_word(FUNC_INSERT, pick_value(1'b0), pos);
      end else if (roll < ins_pct + rem_pct) begin
        send_word(FUNC_REMOVE, pick_value(1'b1), pos);
      end else begin
        // Most reads hit a stored entry; the rest use a random position, which may lie beyond the count.
        if (sb.n_stored > 0 && $urandom_range(99) < 80) pos = $urandom_range(sb.n_stored - 1);
        send_word(FUNC_READ, $urandom(), pos);
      end
    end

    // Wait for every outstanding result, then watch for stray words.
    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_dp.sv
rtl/sorted_list_insert_remove_unit.sv
tb/tb.sv
